// File: sv/timed_valve_sequencer_unit_assert.svh
// assertion helpers used by the checker file
`ifndef TIMED_VALVE_SEQUENCER_UNIT_ASSERT_SVH
`define TIMED_VALVE_SEQUENCER_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define TVS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define TVS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/tvs_pkg.sv
package tvs_pkg;

   // default sizing
   localparam int MAX_VALVES_DEFAULT = 64;
   localparam int TIME_BITS_DEFAULT  = 24;

   // milliseconds per minute
   localparam logic [15:0] MS_PER_MINUTE = 16'd60000;

   // request kinds
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_VALVE = 2'd1;
   localparam logic [1:0] REQ_CYCLE = 2'd2;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_SYSTEM_ENABLE = 1'b0,
      CSR_VALVES_IN_USE = 1'b1
   } tvs_csr_type;

   // input transaction
   typedef struct packed {
      logic [1:0]  req_type;
      logic [5:0]  valve_index;
      logic        valve_enable;
      logic [23:0] on_time_ms;
      logic [7:0]  cycle_minutes;
   } tvs_req_type;

   // result transaction
   typedef struct packed {
      logic       accepted;
      logic       valve_open;
      logic [5:0] open_valve;
      logic [6:0] position;
      logic       sequence_done;
      logic       cycle_restart;
   } tvs_rsp_type;

   // valve table control
   typedef struct packed {
      logic wr_valid;
      logic wr_enable_bit;
      logic old_rd;
   } tvs_tbl_ctl_type;

endpackage

// File: sv/timed_valve_sequencer_unit.sv
// Timed valve sequencer: opens valves one at a time in table order on millisecond ticks,
// skips disabled valves, then waits for the cycle timer to reach the cycle length before
// restarting at the first valve. Requests are ticks, valve table writes (enable bit and
// on-time) and cycle length requests, which are refused unless three quarters of the new
// length exceeds the running sum of all on-times. One transaction is accepted per clock
// cycle while the rsp side is not stalled. That rate is set by the valve table, whose
// registered read port is addressed with the next sequence position so that the current
// valve's settings are ready on every cycle. The table resets to all valves disabled with
// zero on-time; no clearing pass is needed.
module timed_valve_sequencer_unit
   import tvs_pkg::*;
#(
   parameter int MAX_VALVES = MAX_VALVES_DEFAULT,
   parameter int TIME_BITS  = TIME_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  tvs_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output tvs_rsp_type rsp_payload,
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [6:0]  csr_wr_data
);

   localparam int IDX_W = (MAX_VALVES > 1) ? $clog2(MAX_VALVES) : 1;
   localparam int TOT_W = TIME_BITS + IDX_W;
   localparam logic [TIME_BITS-1:0] TIME_ALL_ONES = '1;

   // configuration
   logic       system_enable_ff;
   logic       system_enable_in;
   logic [6:0] valves_in_use_ff;
   logic [6:0] valves_in_use_in;

   // input register
   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic [1:0]           in_type_ff;
   logic                 in_idx_ok_ff;
   logic [IDX_W-1:0]     in_addr_ff;
   logic                 in_enable_ff;
   logic [TIME_BITS-1:0] in_on_ff;
   logic [TIME_BITS-1:0] in_cyc_ms_ff;

   // sequencer state
   logic [6:0]           seq_position_ff;
   logic [6:0]           seq_position_in;
   logic                 valve_is_open_ff;
   logic                 valve_is_open_in;
   logic [TIME_BITS-1:0] valve_elapsed_ff;
   logic [TIME_BITS-1:0] valve_elapsed_in;
   logic [TIME_BITS-1:0] cycle_elapsed_ff;
   logic [TIME_BITS-1:0] cycle_elapsed_in;
   logic [TIME_BITS-1:0] cycle_length_ff;
   logic [TIME_BITS-1:0] cycle_length_in;
   logic [TOT_W-1:0]     total_on_ff;
   logic [TOT_W-1:0]     total_on_in;

   // result register
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   tvs_rsp_type rsp_payload_ff;
   tvs_rsp_type rsp_payload_in;

   // handshake and intake
   logic                 req_accept;
   logic                 advance;
   logic                 idx_ok;
   logic [TIME_BITS-1:0] sat_on;
   logic [23:0]          cyc_prod;
   logic [TIME_BITS-1:0] sat_cyc_ms;

   // table interface
   tvs_tbl_ctl_type      tbl_ctl;
   logic [IDX_W-1:0]     pos_addr;
   logic [IDX_W-1:0]     old_addr;
   logic                 cur_enable;
   logic [TIME_BITS-1:0] cur_on_time;
   logic [TIME_BITS-1:0] old_on_time;

   // execute helpers
   logic [6:0]           count;
   logic [TIME_BITS-1:0] cyc_inc;
   logic [TIME_BITS-1:0] vel_inc;
   logic [TIME_BITS+1:0] three_ms;
   logic [TIME_BITS-1:0] quarter_ms;
   logic                 accepted;
   logic                 restart;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   // intake: range check and saturation of times
   assign idx_ok   = {3'b000, req_payload.valve_index} < 9'(MAX_VALVES);
   assign cyc_prod = 24'(req_payload.cycle_minutes) * 24'(MS_PER_MINUTE);
   assign sat_on = (33'(req_payload.on_time_ms) > 33'(TIME_ALL_ONES)) ?
                   TIME_ALL_ONES : TIME_BITS'(req_payload.on_time_ms);
   assign sat_cyc_ms = (33'(cyc_prod) > 33'(TIME_ALL_ONES)) ?
                       TIME_ALL_ONES : TIME_BITS'(cyc_prod);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_type_ff   <= req_payload.req_type;
         in_idx_ok_ff <= idx_ok;
         in_addr_ff   <= old_addr;
         in_enable_ff <= req_payload.valve_enable;
         in_on_ff     <= sat_on;
         in_cyc_ms_ff <= sat_cyc_ms;
      end
   end

   // configuration writes
   always_comb begin
      system_enable_in = system_enable_ff;
      valves_in_use_in = valves_in_use_ff;
      if (csr_wr_en) begin
         unique case (tvs_csr_type'(csr_index))
            CSR_SYSTEM_ENABLE: system_enable_in = csr_wr_data[0];
            CSR_VALVES_IN_USE: valves_in_use_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   // active valve count, capped at the table depth
   assign count = ({2'b00, valves_in_use_ff} > 9'(MAX_VALVES)) ?
                  7'(MAX_VALVES) : valves_in_use_ff;

   assign cyc_inc = (cycle_elapsed_ff == TIME_ALL_ONES) ?
                    cycle_elapsed_ff : cycle_elapsed_ff + 1'b1;
   assign vel_inc = (valve_elapsed_ff == TIME_ALL_ONES) ?
                    valve_elapsed_ff : valve_elapsed_ff + 1'b1;
   assign three_ms   = {2'b00, in_cyc_ms_ff} + {1'b0, in_cyc_ms_ff, 1'b0};
   assign quarter_ms = three_ms[TIME_BITS+1:2];

   // execute the transaction held in the input register
   always_comb begin
      seq_position_in  = seq_position_ff;
      valve_is_open_in = valve_is_open_ff;
      valve_elapsed_in = valve_elapsed_ff;
      cycle_elapsed_in = cycle_elapsed_ff;
      cycle_length_in  = cycle_length_ff;
      total_on_in      = total_on_ff;
      accepted         = 1'b0;
      restart          = 1'b0;
      tbl_ctl.wr_valid      = 1'b0;
      tbl_ctl.wr_enable_bit = in_enable_ff;
      tbl_ctl.old_rd        = req_accept;
      if (advance) begin
         unique case (in_type_ff)
            REQ_TICK: begin
               if (system_enable_ff) begin
                  accepted         = 1'b1;
                  cycle_elapsed_in = cyc_inc;
                  if (seq_position_ff < count) begin
                     if (cur_enable) begin
                        if (!valve_is_open_ff) begin
                           valve_is_open_in = 1'b1;
                           valve_elapsed_in = '0;
                        end else begin
                           valve_elapsed_in = vel_inc;
                           if (vel_inc >= cur_on_time) begin
                              valve_is_open_in = 1'b0;
                              seq_position_in  = seq_position_ff + 1'b1;
                           end
                        end
                     end else begin
                        // disabled valve is skipped
                        valve_is_open_in = 1'b0;
                        seq_position_in  = seq_position_ff + 1'b1;
                     end
                  end else begin
                     valve_is_open_in = 1'b0;
                     if (cyc_inc >= cycle_length_ff) begin
                        seq_position_in  = '0;
                        cycle_elapsed_in = '0;
                        restart          = 1'b1;
                     end
                  end
               end
            end
            REQ_VALVE: begin
               if (in_idx_ok_ff) begin
                  accepted         = 1'b1;
                  tbl_ctl.wr_valid = 1'b1;
                  total_on_in = total_on_ff - TOT_W'(old_on_time) + TOT_W'(in_on_ff);
               end
            end
            REQ_CYCLE: begin
               if (TOT_W'(quarter_ms) > total_on_ff) begin
                  accepted        = 1'b1;
                  cycle_length_in = in_cyc_ms_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // table addresses: out of range positions read entry zero and are never used
   assign pos_addr = ({2'b00, seq_position_in} < 9'(MAX_VALVES)) ?
                     IDX_W'(seq_position_in) : '0;
   assign old_addr = idx_ok ? IDX_W'(req_payload.valve_index) : '0;

   tvs_valve_table #(
      .MAX_VALVES (MAX_VALVES),
      .TIME_BITS  (TIME_BITS)
   ) u_valve_table (
      .clock       (clock),
      .reset       (reset),
      .ctl         (tbl_ctl),
      .wr_addr     (in_addr_ff),
      .wr_on_time  (in_on_ff),
      .pos_addr    (pos_addr),
      .old_addr    (old_addr),
      .cur_enable  (cur_enable),
      .cur_on_time (cur_on_time),
      .old_on_time (old_on_time)
   );

   // result formation
   always_comb begin
      rsp_payload_in.accepted      = accepted;
      rsp_payload_in.valve_open    = valve_is_open_in;
      rsp_payload_in.open_valve    = valve_is_open_in ? seq_position_in[5:0] : 6'd0;
      rsp_payload_in.position      = seq_position_in;
      rsp_payload_in.sequence_done = seq_position_in >= count;
      rsp_payload_in.cycle_restart = restart;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         system_enable_ff <= 1'b0;
         valves_in_use_ff <= '0;
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         seq_position_ff  <= '0;
         valve_is_open_ff <= 1'b0;
         valve_elapsed_ff <= '0;
         cycle_elapsed_ff <= '0;
         cycle_length_ff  <= '0;
         total_on_ff      <= '0;
      end else begin
         system_enable_ff <= system_enable_in;
         valves_in_use_ff <= valves_in_use_in;
         in_valid_ff      <= in_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         seq_position_ff  <= seq_position_in;
         valve_is_open_ff <= valve_is_open_in;
         valve_elapsed_ff <= valve_elapsed_in;
         cycle_elapsed_ff <= cycle_elapsed_in;
         cycle_length_ff  <= cycle_length_in;
         total_on_ff      <= total_on_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// File: sv/tvs_valve_table.sv
module tvs_valve_table
   import tvs_pkg::*;
#(
   parameter int MAX_VALVES = MAX_VALVES_DEFAULT,
   parameter int TIME_BITS  = TIME_BITS_DEFAULT,
   localparam int IDX_W     = (MAX_VALVES > 1) ? $clog2(MAX_VALVES) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tvs_tbl_ctl_type      ctl,
   input  logic [IDX_W-1:0]     wr_addr,
   input  logic [TIME_BITS-1:0] wr_on_time,
   input  logic [IDX_W-1:0]     pos_addr,
   input  logic [IDX_W-1:0]     old_addr,
   output logic                 cur_enable,
   output logic [TIME_BITS-1:0] cur_on_time,
   output logic [TIME_BITS-1:0] old_on_time
);

   // entry layout: enable bit over on-time
   logic [TIME_BITS:0]    table_mem_ff [MAX_VALVES];
   logic [MAX_VALVES-1:0] entry_vld_ff;
   logic [MAX_VALVES-1:0] entry_vld_in;
   logic [TIME_BITS:0]    wr_word;

   // position read port
   logic [TIME_BITS:0] pos_q_ff;
   logic               pos_vld_ff;
   logic               pos_vld_in;
   logic               pos_byp_ff;
   logic               pos_byp_in;
   logic [TIME_BITS:0] pos_byp_data_ff;

   // old on-time read port
   logic [TIME_BITS:0] old_q_ff;
   logic               old_vld_ff;
   logic               old_vld_in;
   logic               old_byp_ff;
   logic               old_byp_in;
   logic [TIME_BITS:0] old_byp_data_ff;

   logic [TIME_BITS:0] cur_word;
   logic [TIME_BITS:0] old_word;

   assign wr_word = {ctl.wr_enable_bit, wr_on_time};

   // valid bits and bypass flags
   always_comb begin
      entry_vld_in = entry_vld_ff;
      if (ctl.wr_valid) begin
         entry_vld_in[wr_addr] = 1'b1;
      end
      pos_vld_in = entry_vld_ff[pos_addr];
      pos_byp_in = ctl.wr_valid && (wr_addr == pos_addr);
      old_vld_in = old_vld_ff;
      old_byp_in = old_byp_ff;
      if (ctl.old_rd) begin
         old_vld_in = entry_vld_ff[old_addr];
         old_byp_in = ctl.wr_valid && (wr_addr == old_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_vld_ff <= '0;
         pos_vld_ff   <= 1'b0;
         pos_byp_ff   <= 1'b0;
         old_vld_ff   <= 1'b0;
         old_byp_ff   <= 1'b0;
      end else begin
         entry_vld_ff <= entry_vld_in;
         pos_vld_ff   <= pos_vld_in;
         pos_byp_ff   <= pos_byp_in;
         old_vld_ff   <= old_vld_in;
         old_byp_ff   <= old_byp_in;
      end
   end

   // memory write and registered reads
   always_ff @(posedge clock) begin
      if (ctl.wr_valid) begin
         table_mem_ff[wr_addr] <= wr_word;
      end
      pos_q_ff        <= table_mem_ff[pos_addr];
      pos_byp_data_ff <= wr_word;
      if (ctl.old_rd) begin
         old_q_ff        <= table_mem_ff[old_addr];
         old_byp_data_ff <= wr_word;
      end
   end

   // entries never written read as zero
   always_comb begin
      if (pos_byp_ff) begin
         cur_word = pos_byp_data_ff;
      end else if (pos_vld_ff) begin
         cur_word = pos_q_ff;
      end else begin
         cur_word = '0;
      end
      if (old_byp_ff) begin
         old_word = old_byp_data_ff;
      end else if (old_vld_ff) begin
         old_word = old_q_ff;
      end else begin
         old_word = '0;
      end
   end

   assign cur_enable  = cur_word[TIME_BITS];
   assign cur_on_time = cur_word[TIME_BITS-1:0];
   assign old_on_time = old_word[TIME_BITS-1:0];

endmodule

// File: sv/tvs_checker.sv
`include "timed_valve_sequencer_unit_assert.svh"

module tvs_checker
   import tvs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input tvs_rsp_type rsp_payload
);

   // a stalled result stays put
   `TVS_ASSERT_NEXT(rsp_hold_chk, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "result changed while stalled")

   // a restart lands on position zero with the valve closed
   `TVS_ASSERT_SAME(restart_chk, clock, reset, rsp_valid && rsp_payload.cycle_restart, rsp_payload.accepted && !rsp_payload.valve_open && rsp_payload.position == 7'd0, "bad cycle restart")

   // no open valve reported when closed
   `TVS_ASSERT_SAME(closed_chk, clock, reset, rsp_valid && !rsp_payload.valve_open, rsp_payload.open_valve == 6'd0, "open valve set while closed")

   // an empty result side never blocks intake
   `TVS_ASSERT_SAME(intake_chk, clock, reset, !rsp_valid, req_ready, "intake blocked with no result pending")

endmodule

bind timed_valve_sequencer_unit tvs_checker u_tvs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
